/* rtl/ps2md_pkg.sv */
// ----------------------------------------------------------------------------
// PS/2 mouse packet decoder package
// Shared constants, the event word layout and the packet decode function.
// ----------------------------------------------------------------------------
package ps2md_pkg;

  // Configuration register indexes.
  localparam int unsigned CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] CFG_WHEEL_ENABLE       = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_FIVE_BUTTON_ENABLE = 1'b1;

  // Bit positions inside the first (status) byte of a packet.
  localparam int unsigned B0_LEFT   = 0;
  localparam int unsigned B0_RIGHT  = 1;
  localparam int unsigned B0_MIDDLE = 2;
  localparam int unsigned B0_X_SIGN = 4;
  localparam int unsigned B0_Y_SIGN = 5;
  localparam int unsigned B0_X_OVF  = 6;
  localparam int unsigned B0_Y_OVF  = 7;

  // Bit positions inside the fourth byte.
  localparam int unsigned B3_BTN4 = 4;
  localparam int unsigned B3_BTN5 = 5;

  // Byte positions inside a packet.
  localparam logic [1:0] POS_LAST_SHORT = 2'd2;
  localparam logic [1:0] POS_LAST_LONG  = 2'd3;

  // One decoded event, packed so that move_x sits in the lowest bits.
  typedef struct packed {
    logic [4:0] pad;
    logic       button_fifth;
    logic       button_fourth;
    logic       button_middle;
    logic       button_right;
    logic       button_left;
    logic [3:0] wheel_step;   // two's complement
    logic [8:0] move_y;       // two's complement
    logic [8:0] move_x;       // two's complement
  } ps2md_event_t;

  // Builds an event from the three stored bytes and the fourth byte.
  function automatic ps2md_event_t ps2md_decode(input logic [7:0] b0,
                                                input logic [7:0] b1,
                                                input logic [7:0] b2,
                                                input logic [7:0] b3,
                                                input logic       wheel,
                                                input logic       five);
    ps2md_event_t ev;
    logic         ovf;
    ovf              = b0[B0_X_OVF] | b0[B0_Y_OVF];
    ev               = '0;
    ev.move_x        = ovf ? 9'd0 : {b0[B0_X_SIGN], b1};
    ev.move_y        = ovf ? 9'd0 : {b0[B0_Y_SIGN], b2};
    ev.wheel_step    = wheel ? b3[3:0] : 4'd0;
    ev.button_left   = b0[B0_LEFT];
    ev.button_right  = b0[B0_RIGHT];
    ev.button_middle = b0[B0_MIDDLE];
    ev.button_fourth = wheel & five & b3[B3_BTN4];
    ev.button_fifth  = wheel & five & b3[B3_BTN5];
    return ev;
  endfunction

endpackage

/* rtl/ps2_mouse_packet_decoder.sv */
// ----------------------------------------------------------------------------
// PS/2 mouse packet decoder
// Gathers mouse bytes into 3- or 4-byte packets and emits one decoded event
// (buttons, 9-bit X/Y movement, wheel step) per complete packet.
// ----------------------------------------------------------------------------
// Data path: a byte is captured in the input register; the event that the
// last byte of a packet completes is then loaded into the result register,
// which drives the output.
// Throughput: one byte per cycle while the output is not stalled, set by the
// single input register stage feeding the result register. Reset (rst_ni low,
// asynchronous) empties both stages, restarts packet assembly at the first
// byte and clears both mode registers, so the block starts in 3-byte mode.
module ps2_mouse_packet_decoder
  import ps2md_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  // Configuration write port.
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic               cfg_data_i,
  // Byte input stream.
  input  logic               s_axis_tvalid_i,
  output logic               s_axis_tready_o,
  input  logic [7:0]         s_axis_tdata_i,   // [7:0] data_byte
  input  logic               s_axis_tuser_i,   // [0] from_mouse
  // Event output stream.
  output logic               m_axis_tvalid_o,
  input  logic               m_axis_tready_i,
  // [8:0] move_x, [17:9] move_y, [21:18] wheel_step, [22] button_left,
  // [23] button_right, [24] button_middle, [25] button_fourth,
  // [26] button_fifth, [31:27] zero
  output logic [31:0]        m_axis_tdata_o
);

  // Mode registers.
  logic wheel_q, five_q;

  // Input register stage.
  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_mouse_q;

  // Packet assembly state.
  logic [1:0] pos_q, pos_d;
  logic [7:0] pkt0_q, pkt1_q, pkt2_q;

  // Result register.
  logic         out_valid_q;
  ps2md_event_t out_q;

  logic         four;
  logic         emit;
  logic         out_free;
  logic         advance;
  logic [7:0]   y_byte;
  ps2md_event_t event_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wheel_q <= 1'b0;
      five_q  <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_WHEEL_ENABLE:       wheel_q <= cfg_data_i;
        CFG_FIVE_BUTTON_ENABLE: five_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Either mode makes packets four bytes long.
  assign four = wheel_q | five_q;

  // The held byte finishes a packet when it is the last byte for this mode.
  // A stray fourth byte in 3-byte mode is dropped and wraps the position.
  assign emit = in_mouse_q &&
                ((four && pos_q == POS_LAST_LONG) || (!four && pos_q == POS_LAST_SHORT));

  // The held byte moves on unless it completes an event that has nowhere to go.
  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign advance         = in_valid_q && (!emit || out_free);
  assign s_axis_tready_o = !in_valid_q || advance;

  // In 3-byte mode the Y byte is the held byte that completes the packet.
  assign y_byte  = (!four && pos_q == POS_LAST_SHORT) ? in_byte_q : pkt2_q;
  assign event_d = ps2md_decode(pkt0_q, pkt1_q, y_byte, in_byte_q, wheel_q, five_q);

  always_comb begin
    pos_d = pos_q;
    if (in_mouse_q) begin
      pos_d = emit ? 2'd0 : pos_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_byte_q  <= s_axis_tdata_i;
      in_mouse_q <= s_axis_tuser_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= 2'd0;
      pkt0_q <= 8'd0;
      pkt1_q <= 8'd0;
      pkt2_q <= 8'd0;
    end else if (advance) begin
      pos_q <= pos_d;
      if (in_mouse_q && !emit) begin
        case (pos_q)
          2'd0:    pkt0_q <= in_byte_q;
          2'd1:    pkt1_q <= in_byte_q;
          2'd2:    pkt2_q <= in_byte_q;
          default: ;
        endcase
      end else if (in_mouse_q && !four) begin
        pkt2_q <= in_byte_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && emit) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && emit) begin
      out_q <= event_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_q;

`ifndef SYNTHESIS
  // A completed packet never overwrites an event that is still waiting.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !m_axis_tready_i && emit |-> !advance)
    else $error("event overwritten while stalled");

  // Packet assembly restarts after every emitted event.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && emit |=> pos_q == 2'd0 && out_valid_q)
    else $error("position not restarted after event");

  // Overflow in the status byte forces zero movement.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && emit && (pkt0_q[B0_X_OVF] || pkt0_q[B0_Y_OVF])
      |=> out_q.move_x == 9'd0 && out_q.move_y == 9'd0)
    else $error("movement not zeroed on overflow");

  // Bytes from the keyboard leave the packet position alone.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && !in_mouse_q |=> $stable(pos_q))
    else $error("non-mouse byte moved the packet position");
`endif

endmodule
